/* rtl/core/whp_pkg.sv */
// Shared types and constants of the WAV header parser.
// No dependencies.
package whp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_RIFF_SIZE = 32'd44;
  localparam logic [31:0] MIN_FMT_SIZE  = 32'd16;

  localparam logic [15:0] PCM_CODE = 16'd1;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_NO_RIFF  = 4'd1;
  localparam logic [3:0] ERR_SMALL    = 4'd2;
  localparam logic [3:0] ERR_NO_WAVE  = 4'd3;
  localparam logic [3:0] ERR_NO_FMT   = 4'd4;
  localparam logic [3:0] ERR_SHORT    = 4'd5;
  localparam logic [3:0] ERR_NOT_PCM  = 4'd6;
  localparam logic [3:0] ERR_CHANNELS = 4'd7;
  localparam logic [3:0] ERR_BITS     = 4'd8;
  localparam logic [3:0] ERR_NO_DATA  = 4'd9;

  localparam logic [1:0] FMT_8_MONO    = 2'd0;
  localparam logic [1:0] FMT_16_MONO   = 2'd1;
  localparam logic [1:0] FMT_8_STEREO  = 2'd2;
  localparam logic [1:0] FMT_16_STEREO = 2'd3;

  typedef struct packed {
    logic               header_ok;
    logic [3:0]         error_code;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        sample_bits;
    logic signed [31:0] payload_size;
    logic [30:0]        payload_offset;
    logic [1:0]         format_code;
  } result_t;

endpackage

/* rtl/core/whp_ifs.sv */
// Channel interfaces of the WAV header parser: byte stream, verdict, config.
// No dependencies.
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface whp_out_if;
  logic               valid;
  logic               ready;
  logic               header_ok;
  logic [3:0]         error_code;
  logic [15:0]        channel_count;
  logic [31:0]        sample_rate;
  logic [31:0]        byte_rate;
  logic [15:0]        block_align;
  logic [15:0]        sample_bits;
  logic signed [31:0] payload_size;
  logic [30:0]        payload_offset;
  logic [1:0]         format_code;
  modport source (output valid, output header_ok, output error_code, output channel_count,
                  output sample_rate, output byte_rate, output block_align,
                  output sample_bits, output payload_size, output payload_offset,
                  output format_code, input ready);
  modport sink   (input valid, input header_ok, input error_code, input channel_count,
                  input sample_rate, input byte_rate, input block_align,
                  input sample_bits, input payload_size, input payload_offset,
                  input format_code, output ready);
endinterface

interface whp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] file_size;
  modport source (output valid, output file_size, input ready);
  modport sink   (input valid, input file_size, output ready);
endinterface

/* rtl/core/whp_parse.sv */
// Per-byte parse state and verdict logic of the WAV header parser.
// Depends on whp_pkg.
module whp_parse #(
  parameter int OFFSET_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            first_byte,
  input  logic [30:0]     file_size,
  output logic            res_valid,
  output whp_pkg::result_t res
);
  import whp_pkg::*;

  localparam int OB = OFFSET_BITS;

  typedef enum logic [3:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_SCAN, PH_FSIZE, PH_FCODE,
    PH_CHAN, PH_FIELDS, PH_WAIT, PH_DONE
  } phase_t;

  phase_t         phase, phase_next;
  logic [OB-1:0]  byte_offset, byte_offset_next;
  logic [31:0]    word_shift, word_shift_next;
  logic [OB-1:0]  fmt_end, fmt_end_next;
  logic [15:0]    channels, channels_next;
  logic [31:0]    srate, srate_next;
  logic [31:0]    brate, brate_next;
  logic [15:0]    balign, balign_next;
  logic [15:0]    bits, bits_next;
  logic           data_found, data_found_next;
  logic           data_over, data_over_next;
  logic [31:0]    data_size, data_size_next;
  logic [OB-1:0]  data_off, data_off_next;

  // start-of-file view: the stored state, or the cleared state on a start mark
  phase_t         c_phase;
  logic [OB-1:0]  c_off, c_fmt_end, c_data_off;
  logic [31:0]    c_ws, c_srate, c_brate, c_data_size;
  logic [15:0]    c_ch, c_balign, c_bits;
  logic           c_found, c_over;

  logic           busy, word_end, end_lt, end16_lt, hit, pend_hit;
  logic [33:0]    end_ext, fs_ext;
  logic [OB-1:0]  off_inc, rel;
  logic [31:0]    ws_n;
  logic [15:0]    hi16;
  logic [3:0]     code;

  function automatic logic [3:0] pending_code(phase_t ph);
    case (ph)
      PH_RIFF:   return ERR_NO_RIFF;
      PH_SIZE:   return ERR_SMALL;
      PH_WAVE:   return ERR_NO_WAVE;
      PH_SCAN:   return ERR_NO_FMT;
      PH_FSIZE:  return ERR_SHORT;
      PH_FCODE:  return ERR_NOT_PCM;
      PH_CHAN:   return ERR_CHANNELS;
      PH_FIELDS: return ERR_BITS;
      default:   return ERR_NO_DATA;
    endcase
  endfunction

  function automatic result_t make_result(logic [3:0] err, logic [15:0] ch, logic [31:0] sr,
                                          logic [31:0] br, logic [15:0] ba, logic [15:0] bt,
                                          logic [31:0] sz, logic [30:0] po);
    result_t r;
    r.header_ok      = (err == ERR_OK);
    r.error_code     = err;
    r.channel_count  = ch;
    r.sample_rate    = sr;
    r.byte_rate      = br;
    r.block_align    = ba;
    r.sample_bits    = bt;
    r.payload_size   = (err == ERR_OK) ? sz : 32'sd0;
    r.payload_offset = (err == ERR_OK) ? po : 31'd0;
    if (ch == 16'd1 && bt == 16'd8)       r.format_code = FMT_8_MONO;
    else if (ch == 16'd1 && bt == 16'd16) r.format_code = FMT_16_MONO;
    else if (ch == 16'd2 && bt == 16'd8)  r.format_code = FMT_8_STEREO;
    else                                  r.format_code = FMT_16_STEREO;
    return r;
  endfunction

  always_comb begin
    if (first_byte) begin
      c_phase = PH_RIFF; c_off = '0; c_ws = '0; c_fmt_end = '0;
      c_ch = '0; c_srate = '0; c_brate = '0; c_balign = '0; c_bits = '0;
      c_found = 1'b0; c_over = 1'b0; c_data_size = '0; c_data_off = '0;
    end else begin
      c_phase = phase; c_off = byte_offset; c_ws = word_shift; c_fmt_end = fmt_end;
      c_ch = channels; c_srate = srate; c_brate = brate; c_balign = balign; c_bits = bits;
      c_found = data_found; c_over = data_over; c_data_size = data_size;
      c_data_off = data_off;
    end

    busy     = (c_phase == PH_DONE) || (c_off == '1);
    ws_n     = {data_byte, c_ws[31:8]};
    hi16     = ws_n[31:16];
    off_inc  = c_off + OB'(1);
    end_ext  = 34'(c_off) + 34'd1;
    fs_ext   = 34'(file_size);
    end_lt   = end_ext < fs_ext;
    end16_lt = (end_ext + 34'd16) < fs_ext;
    word_end = (c_off >= OB'(15)) && (c_off[1:0] == 2'b11);
    rel      = c_off - c_fmt_end;

    phase_next = c_phase; byte_offset_next = c_off; word_shift_next = c_ws;
    fmt_end_next = c_fmt_end; channels_next = c_ch; srate_next = c_srate;
    brate_next = c_brate; balign_next = c_balign; bits_next = c_bits;
    data_found_next = c_found; data_over_next = c_over;
    data_size_next = c_data_size; data_off_next = c_data_off;
    hit  = 1'b0;
    code = ERR_OK;

    if (!busy) begin
      word_shift_next  = ws_n;
      byte_offset_next = off_inc;

      // data tag tracking runs alongside the fmt checks
      if (word_end && !c_over) begin
        if (!c_found) begin
          if (ws_n == TAG_DATA && end_lt)        data_found_next = 1'b1;
          else if (ws_n == TAG_DATA || !end_lt)  data_over_next  = 1'b1;
        end else begin
          data_size_next = ws_n;
          data_off_next  = off_inc;
          data_over_next = 1'b1;
        end
      end

      case (c_phase)
        PH_RIFF: begin
          if (c_off == OB'(3)) begin
            if (ws_n == TAG_RIFF) phase_next = PH_SIZE;
            else begin hit = 1'b1; code = ERR_NO_RIFF; end
          end
        end
        PH_SIZE: begin
          if (c_off == OB'(7)) begin
            if (!ws_n[31] && ws_n >= MIN_RIFF_SIZE) phase_next = PH_WAVE;
            else begin hit = 1'b1; code = ERR_SMALL; end
          end
        end
        PH_WAVE: begin
          if (c_off == OB'(11)) begin
            if (ws_n == TAG_WAVE) phase_next = PH_SCAN;
            else begin hit = 1'b1; code = ERR_NO_WAVE; end
          end
        end
        PH_SCAN: begin
          if (word_end) begin
            if (ws_n == TAG_FMT && end16_lt) begin
              fmt_end_next = off_inc;
              phase_next   = PH_FSIZE;
            end else if (ws_n == TAG_FMT || !end_lt) begin
              hit = 1'b1; code = ERR_NO_FMT;
            end
          end
        end
        PH_FSIZE: begin
          if (rel == OB'(3)) begin
            if (!ws_n[31] && ws_n >= MIN_FMT_SIZE) phase_next = PH_FCODE;
            else begin hit = 1'b1; code = ERR_SHORT; end
          end
        end
        PH_FCODE: begin
          if (rel == OB'(5)) begin
            if (hi16 == PCM_CODE) phase_next = PH_CHAN;
            else begin hit = 1'b1; code = ERR_NOT_PCM; end
          end
        end
        PH_CHAN: begin
          if (rel == OB'(7)) begin
            channels_next = hi16;
            if (hi16 == 16'd1 || hi16 == 16'd2) phase_next = PH_FIELDS;
            else begin hit = 1'b1; code = ERR_CHANNELS; end
          end
        end
        PH_FIELDS: begin
          if (rel == OB'(11))      srate_next  = ws_n;
          else if (rel == OB'(15)) brate_next  = ws_n;
          else if (rel == OB'(17)) balign_next = hi16;
          else if (rel == OB'(19)) begin
            bits_next = hi16;
            if (hi16 == 16'd8 || hi16 == 16'd16) phase_next = PH_WAIT;
            else begin hit = 1'b1; code = ERR_BITS; end
          end
        end
        default: ;
      endcase

      if (phase_next == PH_WAIT && data_over_next) begin
        hit  = 1'b1;
        code = data_found_next ? ERR_OK : ERR_NO_DATA;
      end
      if (hit) phase_next = PH_DONE;
    end

    // a start mark closes an undecided file with the check it was waiting on
    pend_hit = first_byte && (byte_offset != '0) && (phase != PH_DONE);
    if (pend_hit)
      res = make_result(pending_code(phase), channels, srate, brate, balign, bits,
                        32'd0, 31'd0);
    else
      res = make_result(code, channels_next, srate_next, brate_next, balign_next,
                        bits_next, data_size_next, 31'(data_off_next));
    res_valid = step && (pend_hit || hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF; byte_offset <= '0; word_shift <= '0; fmt_end <= '0;
      channels <= '0; srate <= '0; brate <= '0; balign <= '0; bits <= '0;
      data_found <= 1'b0; data_over <= 1'b0; data_size <= '0; data_off <= '0;
    end else if (step) begin
      phase <= phase_next; byte_offset <= byte_offset_next;
      word_shift <= word_shift_next; fmt_end <= fmt_end_next;
      channels <= channels_next; srate <= srate_next; brate <= brate_next;
      balign <= balign_next; bits <= bits_next;
      data_found <= data_found_next; data_over <= data_over_next;
      data_size <= data_size_next; data_off <= data_off_next;
    end
  end

  a_done_after_verdict: assert property (@(posedge clk) disable iff (rst)
    step && hit |=> phase == PH_DONE)
    else $error("parse phase not closed after verdict");

  a_offset_advance: assert property (@(posedge clk) disable iff (rst)
    step && !first_byte && phase != PH_DONE && byte_offset != '1
    |=> byte_offset == $past(byte_offset) + OB'(1))
    else $error("byte offset did not advance");

  a_ok_has_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.header_ok |-> data_over_next && data_found_next)
    else $error("header accepted without data chunk");

endmodule

/* rtl/core/whp_out_buf.sv */
// Two-entry result buffer (output register plus skid) for verdicts.
// Depends on whp_pkg.
module whp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  whp_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output whp_pkg::result_t out_data
);
  import whp_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) out_data <= skid_data;
      else if (push)  out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data with output empty");

  a_skid_held: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid)
    else $error("skid entry lost while stalled");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push_ready)
    else $error("buffer accepts while full");

endmodule

/* rtl/core/wav_header_parser_top.sv */
// Top level of the streaming RIFF/WAVE PCM header parser.
// Depends on whp_pkg, whp_ifs (channel interfaces), whp_parse and whp_out_buf.
//
// Usage:
//   stream  - one file byte per transfer, in order; first_byte marks offset 0
//             of a new file. Bytes without a start mark after reset are parsed
//             as a file from offset 0.
//   verdict - one result transfer per file: validity, error code, fmt fields,
//             data chunk size and offset, format code. A start mark arriving
//             while the previous file is undecided first emits an invalid
//             verdict for that file with the pending error.
//   cfg     - file_size write, always ready; write it only while idle.
// Throughput: one byte per cycle while the skid is not full, set by the single-pass
// parse logic between the state registers and the result register.
// Output: a verdict is registered in the result register, or in the skid if stalled.
// Stall: the result register plus a one-entry skid keep stream.ready high
// while one verdict waits; stream.ready drops only while the skid is full.
// Reset (rst, synchronous): clears parse state, both result slots and
// file_size.
module wav_header_parser_top #(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  whp_in_if.sink        stream,
  whp_out_if.source     verdict,
  whp_cfg_if.sink       cfg
);
  import whp_pkg::*;

  logic [30:0] file_size;
  logic        step;
  logic        res_valid;
  logic        buf_ready;
  result_t     res;
  result_t     out_data;

  // config register: always ready, written on every cfg transfer
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg.valid) begin
      file_size <= cfg.file_size;
    end
  end

  // hold input while the skid is full; otherwise take a byte every cycle
  assign stream.ready = buf_ready;
  assign step         = stream.valid && buf_ready;

  whp_parse #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (stream.data_byte),
    .first_byte (stream.first_byte),
    .file_size  (file_size),
    .res_valid  (res_valid),
    .res        (res)
  );

  whp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_valid  (verdict.valid),
    .out_ready  (verdict.ready),
    .out_data   (out_data)
  );

  // unpack the buffered result onto the verdict channel
  assign verdict.header_ok      = out_data.header_ok;
  assign verdict.error_code     = out_data.error_code;
  assign verdict.channel_count  = out_data.channel_count;
  assign verdict.sample_rate    = out_data.sample_rate;
  assign verdict.byte_rate      = out_data.byte_rate;
  assign verdict.block_align    = out_data.block_align;
  assign verdict.sample_bits    = out_data.sample_bits;
  assign verdict.payload_size   = out_data.payload_size;
  assign verdict.payload_offset = out_data.payload_offset;
  assign verdict.format_code    = out_data.format_code;

endmodule

/* tb/tb_top.sv */
// Testbench for wav_header_parser_top: streams whole WAV files through the byte
// channel and checks each verdict against a cycle-free model of the header check.
// Depends on whp_pkg, the whp_ifs interfaces and the parser RTL.
`timescale 1ns / 100ps

import whp_pkg::*;

typedef enum logic [3:0] {
  ST_RIFF, ST_SIZE, ST_WAVE, ST_SCAN, ST_FSIZE, ST_FCODE, ST_CHAN, ST_FIELDS, ST_WAIT, ST_DONE
} parse_step_t;

// Tracks one file at a time and queues the verdict each accepted byte decides.
class verdict_board;
  localparam logic [32:0] OFFSET_LAST = 33'h0_FFFF_FFFF;

  logic [30:0] size_limit;
  logic [32:0] offset, fmt_end, data_off;
  logic [31:0] last_word, data_size, rate, brate;
  logic [15:0] chans, align, bits;
  logic        data_seen, data_over, decided;
  parse_step_t step;
  result_t     expected_verdicts[$];
  int          mismatches, verdicts_checked, sent_bytes;

  function new();
    size_limit = '0;
    mismatches = 0;
    verdicts_checked = 0;
    sent_bytes = 0;
    restart();
  endfunction

  function void restart();
    offset = '0;
    fmt_end = '0;
    data_off = '0;
    last_word = '0;
    data_size = '0;
    rate = '0;
    brate = '0;
    chans = '0;
    align = '0;
    bits = '0;
    data_seen = 1'b0;
    data_over = 1'b0;
    decided = 1'b0;
    step = ST_RIFF;
  endfunction

  function void set_size(logic [30:0] v);
    size_limit = v;
  endfunction

  function logic [3:0] pending_error();
    case (step)
      ST_RIFF:   return ERR_NO_RIFF;
      ST_SIZE:   return ERR_SMALL;
      ST_WAVE:   return ERR_NO_WAVE;
      ST_SCAN:   return ERR_NO_FMT;
      ST_FSIZE:  return ERR_SHORT;
      ST_FCODE:  return ERR_NOT_PCM;
      ST_CHAN:   return ERR_CHANNELS;
      ST_FIELDS: return ERR_BITS;
      default:   return ERR_NO_DATA;
    endcase
  endfunction

  function void queue_verdict(logic [3:0] code);
    result_t r;
    r.header_ok = (code == ERR_OK);
    r.error_code = code;
    r.channel_count = chans;
    r.sample_rate = rate;
    r.byte_rate = brate;
    r.block_align = align;
    r.sample_bits = bits;
    r.payload_size = r.header_ok ? data_size : 32'd0;
    r.payload_offset = r.header_ok ? data_off[30:0] : 31'd0;
    if (chans == 16'd1 && bits == 16'd8) r.format_code = FMT_8_MONO;
    else if (chans == 16'd1 && bits == 16'd16) r.format_code = FMT_16_MONO;
    else if (chans == 16'd2 && bits == 16'd8) r.format_code = FMT_8_STEREO;
    else r.format_code = FMT_16_STEREO;
    expected_verdicts.push_back(r);
  endfunction

  function void note_byte(logic [7:0] b, logic first);
    logic [32:0] off, fin, rel;
    logic [15:0] hi;
    logic        at_word, done_now;
    logic [3:0]  code;
    sent_bytes++;
    if (first) begin
      if (offset != '0 && !decided) queue_verdict(pending_error());
      restart();
    end
    if (decided || offset == OFFSET_LAST) return;
    off = offset;
    fin = off + 33'd1;
    last_word = {b, last_word[31:8]};
    hi = last_word[31:16];
    at_word = (off >= 33'd15) && (off[1:0] == 2'd3);
    done_now = 1'b0;
    code = ERR_OK;

    // The data chunk is tracked in the same pass as the fmt checks.
    if (at_word && !data_over) begin
      if (!data_seen) begin
        if (last_word == TAG_DATA && fin < size_limit) data_seen = 1'b1;
        else if (last_word == TAG_DATA || fin >= size_limit) data_over = 1'b1;
      end else begin
        data_size = last_word;
        data_off = fin;
        data_over = 1'b1;
      end
    end

    rel = off - fmt_end;
    case (step)
      ST_RIFF: if (off == 33'd3) begin
        if (last_word == TAG_RIFF) step = ST_SIZE;
        else begin done_now = 1'b1; code = ERR_NO_RIFF; end
      end
      ST_SIZE: if (off == 33'd7) begin
        if (!last_word[31] && last_word >= MIN_RIFF_SIZE) step = ST_WAVE;
        else begin done_now = 1'b1; code = ERR_SMALL; end
      end
      ST_WAVE: if (off == 33'd11) begin
        if (last_word == TAG_WAVE) step = ST_SCAN;
        else begin done_now = 1'b1; code = ERR_NO_WAVE; end
      end
      ST_SCAN: if (at_word) begin
        if (last_word == TAG_FMT && ({1'b0, fin} + 34'd16) < size_limit) begin
          fmt_end = fin;
          step = ST_FSIZE;
        end else if (last_word == TAG_FMT || fin >= size_limit) begin
          done_now = 1'b1;
          code = ERR_NO_FMT;
        end
      end
      ST_FSIZE: if (rel == 33'd3) begin
        if (!last_word[31] && last_word >= MIN_FMT_SIZE) step = ST_FCODE;
        else begin done_now = 1'b1; code = ERR_SHORT; end
      end
      ST_FCODE: if (rel == 33'd5) begin
        if (hi == PCM_CODE) step = ST_CHAN;
        else begin done_now = 1'b1; code = ERR_NOT_PCM; end
      end
      ST_CHAN: if (rel == 33'd7) begin
        chans = hi;
        if (hi == 16'd1 || hi == 16'd2) step = ST_FIELDS;
        else begin done_now = 1'b1; code = ERR_CHANNELS; end
      end
      ST_FIELDS: begin
        if (rel == 33'd11) rate = last_word;
        else if (rel == 33'd15) brate = last_word;
        else if (rel == 33'd17) align = hi;
        else if (rel == 33'd19) begin
          bits = hi;
          if (hi == 16'd8 || hi == 16'd16) step = ST_WAIT;
          else begin done_now = 1'b1; code = ERR_BITS; end
        end
      end
      default: ;
    endcase
    offset = fin;

    if (step == ST_WAIT && data_over) begin
      done_now = 1'b1;
      code = data_seen ? ERR_OK : ERR_NO_DATA;
    end
    if (done_now) begin
      decided = 1'b1;
      step = ST_DONE;
      queue_verdict(code);
    end
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: verdict field %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_verdict(result_t got);
    result_t want;
    if (expected_verdicts.size() == 0) begin
      $display("%0t: unexpected verdict, expected none actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_verdicts.pop_front();
    verdicts_checked++;
    compare_field("header_ok", want.header_ok, got.header_ok);
    compare_field("error_code", want.error_code, got.error_code);
    compare_field("channel_count", want.channel_count, got.channel_count);
    compare_field("sample_rate", want.sample_rate, got.sample_rate);
    compare_field("byte_rate", want.byte_rate, got.byte_rate);
    compare_field("block_align", want.block_align, got.block_align);
    compare_field("sample_bits", want.sample_bits, got.sample_bits);
    compare_field("payload_size", want.payload_size, got.payload_size);
    compare_field("payload_offset", want.payload_offset, got.payload_offset);
    compare_field("format_code", want.format_code, got.format_code);
  endfunction
endclass

module tb_top;
  localparam int ITEMS        = 1150;
  localparam int PHASE_BYTES  = 160;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Mode flags shared by the stimulus and the verdict receiver.
  logic idle_on = 1'b1;
  logic hold_request = 1'b0;

  int          quiet_cycles = 0;
  logic [7:0]  file_bytes[$];
  result_t     seen_verdict;
  verdict_board board = new();

  whp_in_if  stream();
  whp_out_if verdict();
  whp_cfg_if cfg();

  wav_header_parser_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .verdict (verdict),
    .cfg     (cfg)
  );

  always #10 clk = ~clk;

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((stream.valid && stream.ready) || (verdict.valid && verdict.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Verdict monitor: sample at the rising edge, compare against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && verdict.valid && verdict.ready) begin
      seen_verdict.header_ok = verdict.header_ok;
      seen_verdict.error_code = verdict.error_code;
      seen_verdict.channel_count = verdict.channel_count;
      seen_verdict.sample_rate = verdict.sample_rate;
      seen_verdict.byte_rate = verdict.byte_rate;
      seen_verdict.block_align = verdict.block_align;
      seen_verdict.sample_bits = verdict.sample_bits;
      seen_verdict.payload_size = verdict.payload_size;
      seen_verdict.payload_offset = verdict.payload_offset;
      seen_verdict.format_code = verdict.format_code;
      board.check_verdict(seen_verdict);
    end
  end

  // Verdict receiver: short random stalls, plus one long hold on request so the
  // result slots fill and the byte stream backs up.
  initial begin
    verdict.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        verdict.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        verdict.ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      verdict.ready = 1'b1;
    end
  end

  // File image builders: append little-endian fields to file_bytes.
  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_half(logic [15:0] h);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endfunction

  // Pick a 16-bit value outside the two allowed ones, favoring the extremes.
  function automatic logic [15:0] off_value(logic [15:0] a, logic [15:0] b);
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    if (v == a || v == b) v ^= 16'h0100;
    return v;
  endfunction

  function automatic logic [31:0] flip_bit(logic [31:0] w);
    return w ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  // Build one WAV image: mostly well-formed headers with random content, some
  // with a single broken field, some with the data chunk ahead of fmt, and some
  // cut short so they are still undecided when the next file starts.
  task automatic build_file();
    int   fault;
    logic data_first;
    int   cut;
    file_bytes.delete();
    fault = ($urandom_range(0, 99) < 55) ? 0 : $urandom_range(1, 10);
    data_first = ($urandom_range(0, 7) == 0);

    put_word(fault == 1 ? flip_bit(TAG_RIFF) : TAG_RIFF);
    if (fault == 2) begin
      put_word($urandom_range(0, 1) ? $urandom_range(0, 43) : ($urandom | 32'h8000_0000));
    end else begin
      case ($urandom_range(0, 3))
        0:       put_word(MIN_RIFF_SIZE);
        1:       put_word(32'h7FFF_FFFF);
        default: put_word($urandom_range(44, 4000));
      endcase
    end
    put_word(fault == 3 ? flip_bit(TAG_WAVE) : TAG_WAVE);
    repeat ($urandom_range(0, 2)) put_word($urandom);
    if (data_first) begin
      put_word(TAG_DATA);
      put_word($urandom);
    end

    put_word(fault == 4 ? flip_bit(TAG_FMT) : TAG_FMT);
    if (fault == 5) begin
      put_word($urandom_range(0, 1) ? $urandom_range(0, 15) : ($urandom | 32'h8000_0000));
    end else begin
      put_word($urandom_range(0, 3) == 0 ? MIN_FMT_SIZE : $urandom_range(16, 32'h7FFF_FFFF));
    end
    put_half(fault == 6 ? off_value(PCM_CODE, PCM_CODE) : PCM_CODE);
    put_half(fault == 7 ? off_value(16'd1, 16'd2) : 16'($urandom_range(1, 2)));
    put_word($urandom);
    put_word($urandom);
    put_half(16'($urandom));
    put_half(fault == 8 ? off_value(16'd8, 16'd16) : ($urandom_range(0, 1) ? 16'd8 : 16'd16));

    repeat ($urandom_range(0, 2)) put_word($urandom);
    if (!data_first && fault != 9) begin
      put_word(TAG_DATA);
      put_word($urandom);
    end
    // Trailing bytes land after the verdict and must be dropped.
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));

    if (fault == 10) begin
      cut = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  // Offer one byte; called and returning at a falling edge. Valid stays high
  // between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic first);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      stream.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    stream.valid = 1'b1;
    stream.data_byte = b;
    stream.first_byte = first;
    do @(posedge clk); while (!stream.ready);
    // Note the transfer at the falling edge so the monitor never races the model.
    @(negedge clk);
    board.note_byte(b, first);
  endtask

  task automatic send_file(input logic mark);
    foreach (file_bytes[i]) send_byte(file_bytes[i], mark && i == 0);
  endtask

  // Stop sending and wait out every expected verdict plus the pipeline latency.
  task automatic drain();
    stream.valid = 1'b0;
    while (board.expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [30:0] v);
    cfg.valid = 1'b1;
    cfg.file_size = v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
    board.set_size(v);
  endtask

  // Close a phase with a short file that fails on its tag: any undecided file
  // gets its verdict first, and the parser is left with nothing pending.
  task automatic close_phase();
    file_bytes.delete();
    put_word(flip_bit(TAG_RIFF));
    send_file(1'b1);
    drain();
  endtask

  initial begin
    logic [30:0] size_plan[PHASES];
    int          budget;
    stream.valid = 1'b0;
    stream.data_byte = '0;
    stream.first_byte = 1'b0;
    cfg.valid = 1'b0;
    cfg.file_size = '0;

    size_plan[0] = 31'h7FFF_FFFF;
    size_plan[1] = 31'd0;
    size_plan[2] = 31'($urandom_range(1000, 5000));
    size_plan[3] = 31'($urandom_range(30, 64));
    size_plan[4] = 31'($urandom);
    size_plan[5] = 31'($urandom_range(44, 2000));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with file_size still at its reset value of zero.
    // Bytes with no start mark after reset form a file at offset 0; the
    // byte after its verdict is dropped.
    file_bytes.delete();
    put_word(TAG_RIFF ^ 32'h8000_0000);
    file_bytes.push_back(8'hFF);
    send_file(1'b0);
    // A file left undecided, then closed by the next start mark.
    file_bytes.delete();
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h80);
    send_file(1'b1);
    // Negative RIFF size.
    file_bytes.delete();
    put_word(TAG_RIFF);
    put_word(32'hFFFF_FFFF);
    send_file(1'b1);
    // The fmt tag ends too late for a zero file size.
    file_bytes.delete();
    put_word(TAG_RIFF);
    put_word(MIN_RIFF_SIZE);
    put_word(TAG_WAVE);
    put_word(TAG_FMT);
    send_file(1'b1);
    drain();

    // Random part: one file_size setting per phase, extremes included.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_size(size_plan[phase]);
      if (phase == PHASES - 1) idle_on = 1'b0;
      if (phase == 2) begin
        // Hold the receiver and flood short failing files until the input stalls.
        hold_request = 1'b1;
        repeat (10) begin
          file_bytes.delete();
          put_word(flip_bit(TAG_RIFF));
          send_file(1'b1);
        end
      end
      budget = board.sent_bytes + PHASE_BYTES;
      if (phase < PHASES - 1) begin
        while (board.sent_bytes < budget) begin
          build_file();
          send_file(1'b1);
        end
      end else begin
        while (board.sent_bytes < ITEMS) begin
          build_file();
          send_file(1'b1);
        end
      end
      close_phase();
    end

    repeat (10) @(negedge clk);
    if (board.mismatches == 0 && board.expected_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
